### design/prs_pkg.sv
// Shared constants, microcode word format and control store for prime_range_sum_core.
package prs_pkg;

    localparam int VALUE_BITS = 16;
    localparam int SUM_BITS   = 28;
    localparam int DSQ_BITS   = 2 * VALUE_BITS + 1;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int STEP_BITS  = 4;
    localparam int COND_BITS  = 4;

    // Step addresses of the control program.
    localparam logic [STEP_BITS-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_CHECK = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_VLOOP = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_SMALL = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_DLOOP = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_WAIT  = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_TEST  = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_NEXTV = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_PRIME = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_DONE  = 4'd9;

    // Jump conditions: jump to target when true, else fall through.
    localparam logic [COND_BITS-1:0] COND_NEVER       = 4'd0;
    localparam logic [COND_BITS-1:0] COND_ALWAYS      = 4'd1;
    localparam logic [COND_BITS-1:0] COND_NO_INPUT    = 4'd2;
    localparam logic [COND_BITS-1:0] COND_LO_GE_HI    = 4'd3;
    localparam logic [COND_BITS-1:0] COND_V_GE_HI     = 4'd4;
    localparam logic [COND_BITS-1:0] COND_V_LE_ONE    = 4'd5;
    localparam logic [COND_BITS-1:0] COND_DSQ_GT_V    = 4'd6;
    localparam logic [COND_BITS-1:0] COND_MOD_BUSY    = 4'd7;
    localparam logic [COND_BITS-1:0] COND_REM_NONZERO = 4'd8;
    localparam logic [COND_BITS-1:0] COND_NO_OUTACK   = 4'd9;

    typedef struct packed {
        logic [COND_BITS-1:0] cond;
        logic [STEP_BITS-1:0] target;
        logic                 in_ready;
        logic                 out_valid;
        logic                 load_in;
        logic                 set_err;
        logic                 init_v;
        logic                 init_d;
        logic                 mod_start;
        logic                 step_d;
        logic                 add_sum;
        logic                 inc_v;
    } uword_t;

    typedef struct packed {
        logic busy;
        logic rem_zero;
    } mod_status_t;

    function automatic uword_t ucode_rom(input logic [STEP_BITS-1:0] addr);
        uword_t w;
        w = '0;
        case (addr)
            STEP_IDLE: begin
                w.cond = COND_NO_INPUT;  w.target = STEP_IDLE;
                w.in_ready = 1'b1;       w.load_in = 1'b1;
            end
            STEP_CHECK: begin
                w.cond = COND_LO_GE_HI;  w.target = STEP_DONE;
                w.set_err = 1'b1;        w.init_v = 1'b1;
            end
            STEP_VLOOP: begin
                w.cond = COND_V_GE_HI;   w.target = STEP_DONE;
                w.init_d = 1'b1;
            end
            STEP_SMALL: begin
                w.cond = COND_V_LE_ONE;  w.target = STEP_NEXTV;
            end
            STEP_DLOOP: begin
                w.cond = COND_DSQ_GT_V;  w.target = STEP_PRIME;
                w.mod_start = 1'b1;
            end
            STEP_WAIT: begin
                w.cond = COND_MOD_BUSY;  w.target = STEP_WAIT;
            end
            STEP_TEST: begin
                w.cond = COND_REM_NONZERO; w.target = STEP_DLOOP;
                w.step_d = 1'b1;
            end
            STEP_NEXTV: begin
                w.cond = COND_ALWAYS;    w.target = STEP_VLOOP;
                w.inc_v = 1'b1;
            end
            STEP_PRIME: begin
                w.cond = COND_ALWAYS;    w.target = STEP_NEXTV;
                w.add_sum = 1'b1;
            end
            STEP_DONE: begin
                w.cond = COND_NO_OUTACK; w.target = STEP_DONE;
                w.out_valid = 1'b1;
            end
            default: begin
                w.cond = COND_ALWAYS;    w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### design/prime_range_sum_core.sv
// Top level: microcoded sum of primes strictly between two bounds.
//
//  channel | ports                                    | direction | carries
//  --------+------------------------------------------+-----------+------------------------
//  s_      | s_valid s_ready s_lower_bound s_upper_bound | in     | one range per transaction
//  m_      | m_valid m_ready m_prime_sum m_order_error   | out    | one sum per transaction
//
// One range is worked at a time. Each candidate v passes through the sequencer steps and,
// for every trial divisor d with d*d <= v until one divides v, a pass of the bit-serial
// remainder unit. A range with its bounds out of order or equal skips the loop and
// answers with the order error and a zero sum.
// Reset (aresetn low, synchronous) returns the step counter to the idle step.
// A stalled result holds in the done step; s_ready stays low until it is taken.
module prime_range_sum_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [prs_pkg::VALUE_BITS-1:0] s_lower_bound,
    input  logic [prs_pkg::VALUE_BITS-1:0] s_upper_bound,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [prs_pkg::SUM_BITS-1:0]   m_prime_sum,
    output logic                           m_order_error
);

    // Sequencer: step counter and the control word it selects.
    logic [prs_pkg::STEP_BITS-1:0] step_reg, step_next;
    prs_pkg::uword_t               uw;
    logic                          cond_true;

    // Datapath registers.
    logic [prs_pkg::VALUE_BITS-1:0] lo_reg, lo_next;
    logic [prs_pkg::VALUE_BITS-1:0] hi_reg, hi_next;
    logic [prs_pkg::VALUE_BITS-1:0] v_reg, v_next;
    logic [prs_pkg::VALUE_BITS-1:0] d_reg, d_next;
    logic [prs_pkg::DSQ_BITS-1:0]   dsq_reg, dsq_next;
    logic [prs_pkg::SUM_BITS-1:0]   sum_reg, sum_next;
    logic                           err_reg, err_next;

    prs_pkg::mod_status_t mod_st;

    assign uw = prs_pkg::ucode_rom(step_reg);

    prs_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (uw.mod_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .status   (mod_st)
    );

    // Evaluate the jump condition named by the control word.
    always_comb begin
        case (uw.cond)
            prs_pkg::COND_NEVER:       cond_true = 1'b0;
            prs_pkg::COND_ALWAYS:      cond_true = 1'b1;
            prs_pkg::COND_NO_INPUT:    cond_true = !s_valid;
            prs_pkg::COND_LO_GE_HI:    cond_true = (lo_reg >= hi_reg);
            prs_pkg::COND_V_GE_HI:     cond_true = (v_reg >= hi_reg);
            prs_pkg::COND_V_LE_ONE:    cond_true = (v_reg <= prs_pkg::VALUE_BITS'(1));
            prs_pkg::COND_DSQ_GT_V:    cond_true = (dsq_reg > prs_pkg::DSQ_BITS'(v_reg));
            prs_pkg::COND_MOD_BUSY:    cond_true = mod_st.busy;
            prs_pkg::COND_REM_NONZERO: cond_true = !mod_st.rem_zero;
            prs_pkg::COND_NO_OUTACK:   cond_true = !m_ready;
            default:                   cond_true = 1'b1;
        endcase
        step_next = cond_true ? uw.target : step_reg + 1'b1;
    end

    // Datapath actions, one group per control bit.
    always_comb begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        v_next   = v_reg;
        d_next   = d_reg;
        dsq_next = dsq_reg;
        sum_next = sum_reg;
        err_next = err_reg;
        if (uw.load_in) begin
            // capture the bounds and clear the running sum
            lo_next  = s_lower_bound;
            hi_next  = s_upper_bound;
            sum_next = '0;
        end
        if (uw.set_err) begin
            err_next = (lo_reg >= hi_reg);
        end
        if (uw.init_v) begin
            v_next = lo_reg + 1'b1;
        end
        if (uw.init_d) begin
            d_next   = prs_pkg::VALUE_BITS'(2);
            dsq_next = prs_pkg::DSQ_BITS'(4);
        end
        if (uw.step_d) begin
            // advance the divisor; (d+1)^2 = d^2 + 2d + 1
            d_next   = d_reg + 1'b1;
            dsq_next = dsq_reg + prs_pkg::DSQ_BITS'({d_reg, 1'b1});
        end
        if (uw.add_sum) begin
            sum_next = sum_reg + prs_pkg::SUM_BITS'(v_reg);
        end
        if (uw.inc_v) begin
            v_next = v_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= prs_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        v_reg   <= v_next;
        d_reg   <= d_next;
        dsq_reg <= dsq_next;
        sum_reg <= sum_next;
        err_reg <= err_next;
    end

    // Drive the handshakes from the control word; hold the result in registers.
    assign s_ready       = uw.in_ready;
    assign m_valid       = uw.out_valid;
    assign m_prime_sum   = sum_reg;
    assign m_order_error = err_reg;

endmodule

### design/prs_mod_unit.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one quotient bit per cycle.
module prs_mod_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [prs_pkg::VALUE_BITS-1:0] dividend,
    input  logic [prs_pkg::VALUE_BITS-1:0] divisor,
    output prs_pkg::mod_status_t           status
);

    logic [prs_pkg::VALUE_BITS-1:0] shift_reg, shift_next;
    logic [prs_pkg::VALUE_BITS-1:0] dvsr_reg, dvsr_next;
    logic [prs_pkg::VALUE_BITS:0]   rem_reg, rem_next;
    logic [prs_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic [prs_pkg::VALUE_BITS:0]   trial;

    always_comb begin
        shift_next = shift_reg;
        dvsr_next  = dvsr_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        trial      = {rem_reg[prs_pkg::VALUE_BITS-1:0], shift_reg[prs_pkg::VALUE_BITS-1]};
        if (start) begin
            shift_next = dividend;
            dvsr_next  = divisor;
            rem_next   = '0;
            cnt_next   = prs_pkg::CNT_BITS'(prs_pkg::VALUE_BITS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            shift_next = {shift_reg[prs_pkg::VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvsr_reg}) begin
                rem_next = trial - {1'b0, dvsr_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != prs_pkg::CNT_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        dvsr_reg  <= dvsr_next;
        rem_reg   <= rem_next;
    end

    assign status.busy     = busy_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

### design/prs_checker.sv
// Port-level checker for prime_range_sum_core and its bind.
module prs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [prs_pkg::SUM_BITS-1:0]   m_prime_sum,
    input logic                           m_order_error
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_sum) && $stable(m_order_error))
        else $error("result changed while stalled");

    // An order error always reports a zero sum.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_order_error |-> m_prime_sum == '0)
        else $error("order error with nonzero sum");

    // One transaction in flight: no input taken while a result is offered.
    a_one_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // After an input transaction the block is busy and offers no result yet.
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("block not busy after input transaction");

endmodule

bind prime_range_sum_core prs_checker u_prs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_prime_sum   (m_prime_sum),
    .m_order_error (m_order_error)
);

### bench/prime_range_checker.sv
// Checker for prime_range_sum_core: predicts each range sum and compares the results.
module prime_range_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [prs_pkg::VALUE_BITS-1:0] s_lower_bound,
    input  logic [prs_pkg::VALUE_BITS-1:0] s_upper_bound,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [prs_pkg::SUM_BITS-1:0]   m_prime_sum,
    input  logic                           m_order_error,
    output int                             mismatch_count,
    output int                             in_flight,
    output int                             results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [prs_pkg::VALUE_BITS-1:0] lo;
        logic [prs_pkg::VALUE_BITS-1:0] hi;
        logic [prs_pkg::SUM_BITS-1:0]   sum;
        logic                           order_error;
    } range_sum_t;

    range_sum_t expected_sums[$];

    initial begin
        mismatch_count = 0;
        in_flight      = 0;
        results_seen   = 0;
    end

    // Sum the primes strictly between the bounds; the sum wraps at its width.
    function automatic range_sum_t sum_primes_between(
        input logic [prs_pkg::VALUE_BITS-1:0] lo,
        input logic [prs_pkg::VALUE_BITS-1:0] hi
    );
        range_sum_t  r;
        int unsigned v;
        int unsigned d;
        bit          prime;
        r.lo          = lo;
        r.hi          = hi;
        r.sum         = '0;
        r.order_error = 1'b0;
        if (lo >= hi) begin
            r.order_error = 1'b1;
            return r;
        end
        for (v = lo + 1; v < hi; v++) begin
            prime = (v > 1);
            d     = 2;
            while (prime && d * d <= v) begin
                if (v % d == 0)
                    prime = 1'b0;
                d++;
            end
            if (prime)
                r.sum = r.sum + v[prs_pkg::SUM_BITS-1:0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin : watch
        range_sum_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_sums.push_back(sum_primes_between(s_lower_bound, s_upper_bound));
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_sums.size() == 0) begin
                    flag_mismatch($sformatf("sum=%0d error=%0b with no range outstanding",
                                            m_prime_sum, m_order_error));
                end else begin
                    want = expected_sums.pop_front();
                    if (m_prime_sum !== want.sum)
                        flag_mismatch($sformatf("range (%0d,%0d): sum %0d, want %0d",
                                                want.lo, want.hi, m_prime_sum, want.sum));
                    if (m_order_error !== want.order_error)
                        flag_mismatch($sformatf("range (%0d,%0d): order_error %0b, want %0b",
                                                want.lo, want.hi, m_order_error,
                                                want.order_error));
                end
            end
        end
        in_flight = expected_sums.size();
    end

endmodule

### bench/testbench.sv
// Top of the prime_range_sum_core bench: clock, reset, range stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB            = prs_pkg::VALUE_BITS;
    localparam int SB            = prs_pkg::SUM_BITS;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_RANGES = 100;
    // Most ranges are short or low, so a correct run stays far under this limit,
    // which leaves room even if every range hit its worst trial-division path.
    localparam int CYCLE_LIMIT   = 50_000_000;
    // Settle time after the last outstanding sum is drained.
    localparam int SETTLE_CYCLES = 32;
    localparam int BOUND_MAX     = (1 << VB) - 1;

    logic          aclk;
    logic          aresetn       = 1'b0;
    logic          s_valid       = 1'b0;
    logic          s_ready;
    logic [VB-1:0] s_lower_bound = '0;
    logic [VB-1:0] s_upper_bound = '0;
    logic          m_valid;
    logic          m_ready       = 1'b0;
    logic [SB-1:0] m_prime_sum;
    logic          m_order_error;

    int mismatch_count;
    int in_flight;
    int results_seen;

    // Idle percentages for the two sides; the receiver one is read by its driver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int ranges_sent   = 0;
    int ranges_bad    = 0;

    prime_range_sum_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_lower_bound (s_lower_bound),
        .s_upper_bound (s_upper_bound),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_sum   (m_prime_sum),
        .m_order_error (m_order_error)
    );

    prime_range_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_lower_bound  (s_lower_bound),
        .s_upper_bound  (s_upper_bound),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prime_sum    (m_prime_sum),
        .m_order_error  (m_order_error),
        .mismatch_count (mismatch_count),
        .in_flight      (in_flight),
        .results_seen   (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Stall the result channel at random; one fresh draw every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stop a hung run: the block never answering is a failure too.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d ranges outstanding", cycle_count, in_flight);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one range and hold it until the block takes it. Random idle cycles
    // go in front, so gaps land at every step of the block's work. On return
    // the clock has just passed the edge that accepted the transaction.
    task automatic send_range(input logic [VB-1:0] lo, input logic [VB-1:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_lower_bound <= lo;
        s_upper_bound <= hi;
        do
            @(posedge aclk);
        while (!s_ready);
        ranges_sent++;
        if (lo >= hi)
            ranges_bad++;
    endtask

    // Draw one range. Keep the span short wherever values are large, since
    // every prime near the top costs hundreds of trial divisions.
    task automatic pick_range(output logic [VB-1:0] lo, output logic [VB-1:0] hi);
        int kind;
        int a;
        int b;
        int gap;
        kind = $urandom_range(99);
        if (kind < 55) begin
            // low values, wider spans: many primes per range
            b   = $urandom_range(600, 2);
            gap = $urandom_range(64, 1);
            if (gap > b)
                gap = b;
            a = b - gap;
        end else if (kind < 70) begin
            // anywhere in the field, a handful of candidates
            gap = $urandom_range(8, 1);
            a   = $urandom_range(BOUND_MAX - gap, 0);
            b   = a + gap;
        end else begin
            // raw bounds across all bits: often out of order, some equal
            a = $urandom_range(BOUND_MAX, 0);
            b = ($urandom_range(9) == 0) ? a : $urandom_range(BOUND_MAX, 0);
            if (a < b && b - a > 8)
                b = a + $urandom_range(8, 1);
        end
        lo = a[VB-1:0];
        hi = b[VB-1:0];
    endtask

    task automatic send_random(input int count);
        logic [VB-1:0] lo;
        logic [VB-1:0] hi;
        repeat (count) begin
            pick_range(lo, hi);
            send_range(lo, hi);
        end
    endtask

    initial begin : stimulus
        // Directed ranges: bounds out of order or equal (zero and all-ones
        // among them), empty and one-candidate ranges, lower bound of 0,
        // candidate value 1 that is not prime, and the largest 16-bit prime.
        int unsigned dir_lo [18] = '{0, 65535, 65535, 1, 5, 0, 0, 0, 1, 2,
                                     1, 3, 2, 0, 10, 65520, 65530, 32767};
        int unsigned dir_hi [18] = '{0, 65535, 0, 1, 4, 1, 2, 3, 3, 3,
                                     2, 5, 4, 100, 30, 65535, 65535, 32771};
        int i;

        // Hold reset for the first cycles, then release it once.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First profile: sender idles now and then, receiver stalls often.
        send_idle_pct = 29;
        recv_idle_pct <= 67;
        for (i = 0; i < 18; i++)
            send_range(dir_lo[i][VB-1:0], dir_hi[i][VB-1:0]);
        send_random(RANDOM_RANGES / 3);

        // Second profile: swap the two sides.
        send_idle_pct = 67;
        recv_idle_pct <= 29;
        send_random(RANDOM_RANGES / 3);

        // Last profile: run back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        send_random(RANDOM_RANGES - 2 * (RANDOM_RANGES / 3));

        // Drop valid, let the checker register the last transaction, then
        // drain every outstanding sum.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Summary: %0d ranges sent, %0d of them with bounds out of order or equal",
                 ranges_sent, ranges_bad);
        $display("Summary: %0d sums checked under three idle and stall profiles in %0d cycles",
                 results_seen, cycle_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
